// ----- rtl/core/bmg_pkg.sv -----
// Shared constants and types for the Box-Muller Gaussian pair generator.
package bmg_pkg;

    localparam int MAG_LAT      = 60;
    localparam int TRIG_LAT     = 17;
    localparam int TRIG_PAD     = MAG_LAT - TRIG_LAT;
    localparam int LOG_ROUNDS   = 26;
    localparam int SQRT_STEPS   = 32;
    localparam int SERIES_TERMS = 6;

    localparam logic [31:0] LN2_Q32     = 32'hB172_17F8;
    localparam logic [32:0] HALF_PI_Q32 = 33'h1_921F_B544;
    localparam logic [31:0] R_SAT       = 32'h7FFF_FFFF;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    // exact reciprocals for n < 2^31: ceil(2^sh / d), sh = 31 + ceil(log2 d)
    // series divisors, innermost term first in index 5
    localparam int SIN_SHIFT [SERIES_TERMS] = '{34, 36, 37, 38, 38, 39};
    localparam int COS_SHIFT [SERIES_TERMS] = '{32, 35, 36, 37, 38, 39};

    localparam logic [32:0] SIN_RECIP [SERIES_TERMS] = '{
        33'(((64'd1 << 34) + 64'd5)   / 64'd6),
        33'(((64'd1 << 36) + 64'd19)  / 64'd20),
        33'(((64'd1 << 37) + 64'd41)  / 64'd42),
        33'(((64'd1 << 38) + 64'd71)  / 64'd72),
        33'(((64'd1 << 38) + 64'd109) / 64'd110),
        33'(((64'd1 << 39) + 64'd155) / 64'd156)
    };
    localparam logic [32:0] COS_RECIP [SERIES_TERMS] = '{
        33'(((64'd1 << 32) + 64'd1)   / 64'd2),
        33'(((64'd1 << 35) + 64'd11)  / 64'd12),
        33'(((64'd1 << 36) + 64'd29)  / 64'd30),
        33'(((64'd1 << 37) + 64'd55)  / 64'd56),
        33'(((64'd1 << 38) + 64'd89)  / 64'd90),
        33'(((64'd1 << 39) + 64'd131) / 64'd132)
    };

    typedef enum logic {
        REG_PAIR_COUNT = 1'b0,
        REG_SWAP_POINT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [30:0] cos_mag;
        logic        cos_neg;
        logic [30:0] sin_mag;
        logic        sin_neg;
    } t_trig;

    typedef struct packed {
        logic fwd;
        logic last;
    } t_side;

    typedef struct packed {
        logic [31:0] z_first;
        logic [31:0] z_second;
        logic        run_last;
    } t_beat;

endpackage

// ----- rtl/core/bmg_magnitude.sv -----
// Pipelined r = sqrt(-2 ln(x/2^32)) in Q4.28: normalize, log2 by squaring, scale, sqrt.
module bmg_magnitude (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x,
    output logic [31:0] o_r
);
    import bmg_pkg::*;

    logic [4:0]  w_pos;
    logic [31:0] w_norm;

    logic [31:0] r_y    [0:LOG_ROUNDS];
    logic [25:0] r_frac [0:LOG_ROUNDS];
    logic [5:0]  r_e    [0:LOG_ROUNDS];
    logic        r_zero [0:LOG_ROUNDS];

    logic [34:0] r_rem  [0:SQRT_STEPS];
    logic [31:0] r_root [0:SQRT_STEPS];
    logic [63:0] r_rad  [0:SQRT_STEPS];
    logic        r_zs   [0:SQRT_STEPS];

    logic [31:0] w_t;
    logic [63:0] w_s_prod;

    // leading one
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_x[i]) begin
                w_pos = 5'(i);
            end
        end
        w_norm = i_x << (5'd31 - w_pos);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y[0]    <= w_norm;
            r_frac[0] <= '0;
            r_e[0]    <= 6'd32 - {1'b0, w_pos};
            r_zero[0] <= (i_x == 32'd0);
        end
    end

    // one squaring round per stage, Q1.31 mantissa
    for (genvar k = 0; k < LOG_ROUNDS; k++) begin : g_log
        logic [63:0] w_sq;
        logic [32:0] w_sh;
        always_comb begin
            w_sq = 64'(r_y[k]) * 64'(r_y[k]);
            w_sh = w_sq[63:31];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[k+1]    <= w_sh[32] ? w_sh[32:1] : w_sh[31:0];
                r_frac[k+1] <= {r_frac[k][24:0], w_sh[32]};
                r_e[k+1]    <= r_e[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    // -log2 a in Q6.26, times ln2 and 2
    always_comb begin
        w_t      = {r_e[LOG_ROUNDS], 26'd0} - {6'd0, r_frac[LOG_ROUNDS]};
        w_s_prod = 64'(w_t) * 64'(LN2_Q32);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_rad[0]  <= {1'b0, w_s_prod[63:1]};
            r_zs[0]   <= r_zero[LOG_ROUNDS];
        end
    end

    // restoring square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [34:0] w_cur;
        logic [34:0] w_trial;
        logic        w_ge;
        always_comb begin
            w_cur   = {r_rem[k][32:0], r_rad[k][63:62]};
            w_trial = {1'b0, r_root[k], 2'b01};
            w_ge    = (w_cur >= w_trial);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? (w_cur - w_trial) : w_cur;
                r_root[k+1] <= {r_root[k][30:0], w_ge};
                r_rad[k+1]  <= {r_rad[k][61:0], 2'b00};
                r_zs[k+1]   <= r_zs[k];
            end
        end
    end

    assign o_r = r_zs[SQRT_STEPS] ? R_SAT : r_root[SQRT_STEPS];

endmodule

// ----- rtl/core/bmg_trig.sv -----
// Pipelined cos and sin of 2 pi b/2^32: octant fold, Horner series, quadrant signs.
module bmg_trig (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [31:0]    i_b,
    output bmg_pkg::t_trig o_trig
);
    import bmg_pkg::*;

    localparam int SER_STAGES = 2 * SERIES_TERMS;

    typedef struct packed {
        logic [1:0]  quad;
        logic        flip;
        logic [30:0] x;
        logic [30:0] x2;
    } t_ctx;

    logic [1:0]  r_q1, r_q2;
    logic        r_f1, r_f2;
    logic [29:0] r_th;
    logic [30:0] r_x2s;
    logic [63:0] w_xprod;
    logic [61:0] w_xsq;

    t_ctx        r_ctx [0:SER_STAGES];
    logic [30:0] r_sv  [0:SER_STAGES];
    logic [30:0] r_cv  [0:SER_STAGES];

    logic [1:0]  r_q16;
    logic        r_f16;
    logic [30:0] r_s16, r_c16;
    logic [61:0] w_sprod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1 <= i_b[31:30];
            r_f1 <= i_b[29];
            r_th <= i_b[29] ? 30'(31'h4000_0000 - {1'b0, i_b[29:0]}) : i_b[29:0];
        end
    end

    always_comb begin
        w_xprod = 64'(r_th) * 64'(HALF_PI_Q32) + 64'h8000_0000;
        w_xsq   = 62'(r_x2s) * 62'(r_x2s);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q2  <= r_q1;
            r_f2  <= r_f1;
            r_x2s <= w_xprod[62:32];
            r_ctx[0] <= '{quad: r_q2, flip: r_f2, x: r_x2s, x2: w_xsq[60:30]};
            r_sv[0]  <= ONE_Q30;
            r_cv[0]  <= ONE_Q30;
        end
    end

    // even stage: x2 * v; odd stage: 1 - p / d
    for (genvar m = 0; m < SER_STAGES; m++) begin : g_ser
        if ((m % 2) == 0) begin : g_mul
            logic [61:0] w_ps, w_pc;
            always_comb begin
                w_ps = 62'(r_ctx[m].x2) * 62'(r_sv[m]);
                w_pc = 62'(r_ctx[m].x2) * 62'(r_cv[m]);
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sv[m+1] <= w_ps[60:30];
                    r_cv[m+1] <= w_pc[60:30];
                end
            end
        end else begin : g_div
            localparam int TERM = SERIES_TERMS - 1 - m / 2;
            logic [63:0] w_qs, w_qc;
            always_comb begin
                w_qs = (64'(r_sv[m]) * 64'(SIN_RECIP[TERM])) >> SIN_SHIFT[TERM];
                w_qc = (64'(r_cv[m]) * 64'(COS_RECIP[TERM])) >> COS_SHIFT[TERM];
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sv[m+1] <= ONE_Q30 - w_qs[30:0];
                    r_cv[m+1] <= ONE_Q30 - w_qc[30:0];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[m+1] <= r_ctx[m];
            end
        end
    end

    assign w_sprod = 62'(r_ctx[SER_STAGES].x) * 62'(r_sv[SER_STAGES]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q16 <= r_ctx[SER_STAGES].quad;
            r_f16 <= r_ctx[SER_STAGES].flip;
            r_s16 <= w_sprod[60:30];
            r_c16 <= r_cv[SER_STAGES];
        end
    end

    logic [30:0] w_s, w_c;
    t_trig       n_trig;

    always_comb begin
        w_s = r_f16 ? r_c16 : r_s16;
        w_c = r_f16 ? r_s16 : r_c16;
        case (r_q16)
            2'd0:    n_trig = '{cos_mag: w_c, cos_neg: 1'b0, sin_mag: w_s, sin_neg: 1'b0};
            2'd1:    n_trig = '{cos_mag: w_s, cos_neg: 1'b1, sin_mag: w_c, sin_neg: 1'b0};
            2'd2:    n_trig = '{cos_mag: w_c, cos_neg: 1'b1, sin_mag: w_s, sin_neg: 1'b1};
            default: n_trig = '{cos_mag: w_s, cos_neg: 1'b0, sin_mag: w_c, sin_neg: 1'b1};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_trig <= n_trig;
        end
    end

endmodule

// ----- rtl/core/box_muller_gaussian_pair.sv -----
// Top level of the Box-Muller Gaussian pair generator.
// Each input beat carries two 32-bit uniform words (fractions u/2^32); each output
// beat carries two Gaussian samples in signed Q4.28 plus a run_last flag. One beat
// enters per cycle and one result leaves per cycle when neither side stalls. The
// pipeline depth is set by the magnitude path: 26 squaring stages for log2 and 32
// stages of square root, each holding one 32x32 multiply or one 35-bit
// compare-subtract. A two-entry output queue lets the block keep taking beats
// while one result waits; the input stalls only while that queue is full, and
// then the whole pipeline holds. Register 0 (byte 0) is pair_count, register 1
// (byte 4) is swap_point; write them only while the block is idle. While the
// pair index is below swap_point, a is the first word and b the second; from
// swap_point on both operands and results swap. A zero operand a saturates the
// magnitude to just below 8.0.
module box_muller_gaussian_pair (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_u_first,
    input  logic [31:0]        i_u_second,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_z_first,
    output logic signed [31:0] o_z_second,
    output logic               o_run_last
);
    import bmg_pkg::*;

    // configuration and run counter
    logic [31:0] r_pair_count, r_swap_point, r_pair_index;
    logic        w_cfg_wr, w_en, w_acc, w_fwd, w_last;

    // input stage
    logic        r_s0_vld;
    logic [31:0] r_s0_a, r_s0_b;
    t_side       r_s0_side;

    // side info and trig results wait out the magnitude latency
    logic        r_vld  [0:MAG_LAT-1];
    t_side       r_side [0:MAG_LAT-1];
    t_trig       r_tpad [0:TRIG_PAD-1];
    logic [31:0] w_r;
    t_trig       w_trig;

    // scaling stage
    logic        r_sc_vld;
    t_side       r_sc_side;
    logic [31:0] r_sc_m0, r_sc_m1;
    logic        r_sc_n0, r_sc_n1;
    logic [63:0] w_p0, w_p1;

    // output queue
    t_beat       r_q [0:1];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push, w_pop;
    logic [31:0] w_z0, w_z1;
    t_beat       w_beat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_PAIR_COUNT: prdata = r_pair_count;
            REG_SWAP_POINT: prdata = r_swap_point;
            default:        prdata = r_pair_count;
        endcase
    end

    // the pipeline moves as one while the queue has room
    assign w_en       = (r_cnt != 2'd2);
    assign o_in_stall = !w_en;
    assign w_acc      = i_in_valid && w_en;

    assign w_fwd  = (r_pair_index < r_swap_point);
    assign w_last = ({1'b0, r_pair_index} + 33'd1) >= {1'b0, r_pair_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= '0;
            r_swap_point <= '0;
            r_pair_index <= '0;
        end else begin
            if (w_cfg_wr) begin
                unique case (t_reg_idx'(paddr[2]))
                    REG_PAIR_COUNT: r_pair_count <= pwdata;
                    REG_SWAP_POINT: r_swap_point <= pwdata;
                    default:        r_pair_count <= r_pair_count;
                endcase
            end
            if (w_acc) begin
                r_pair_index <= w_last ? 32'd0 : r_pair_index + 32'd1;
            end
        end
    end

    // operand order picked on entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s0_a    <= w_fwd ? i_u_first  : i_u_second;
            r_s0_b    <= w_fwd ? i_u_second : i_u_first;
            r_s0_side <= '{fwd: w_fwd, last: w_last};
        end
    end

    bmg_magnitude u_mag (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_s0_a),
        .o_r   (w_r)
    );

    bmg_trig u_trig (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_b    (r_s0_b),
        .o_trig (w_trig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAG_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= r_s0_vld;
            for (int k = 1; k < MAG_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r_s0_side;
            for (int k = 1; k < MAG_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_tpad[0] <= w_trig;
            for (int k = 1; k < TRIG_PAD; k++) begin
                r_tpad[k] <= r_tpad[k-1];
            end
        end
    end

    // |z| = (r * |trig| + 2^29) >> 30, kept to 32 bits
    always_comb begin
        w_p0 = 64'(w_r) * 64'(r_tpad[TRIG_PAD-1].cos_mag) + 64'h2000_0000;
        w_p1 = 64'(w_r) * 64'(r_tpad[TRIG_PAD-1].sin_mag) + 64'h2000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_vld <= 1'b0;
        end else if (w_en) begin
            r_sc_vld <= r_vld[MAG_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sc_side <= r_side[MAG_LAT-1];
            r_sc_m0   <= w_p0[61:30];
            r_sc_m1   <= w_p1[61:30];
            r_sc_n0   <= r_tpad[TRIG_PAD-1].cos_neg;
            r_sc_n1   <= r_tpad[TRIG_PAD-1].sin_neg;
        end
    end

    // signs, then result order
    always_comb begin
        w_z0   = r_sc_n0 ? (32'd0 - r_sc_m0) : r_sc_m0;
        w_z1   = r_sc_n1 ? (32'd0 - r_sc_m1) : r_sc_m1;
        w_beat = '{z_first:  r_sc_side.fwd ? w_z0 : w_z1,
                   z_second: r_sc_side.fwd ? w_z1 : w_z0,
                   run_last: r_sc_side.last};
    end

    assign w_push = w_en && r_sc_vld;
    assign w_pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_beat;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_z_first   = $signed(r_q[r_rp].z_first);
    assign o_z_second  = $signed(r_q[r_rp].z_second);
    assign o_run_last  = r_q[r_rp].run_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_zero_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_pair_count == 32'd0) |=> r_s0_side.last)
        else $error("empty run length must flag every beat as last");

    a_swap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_swap_point == 32'd0) |=> !r_s0_side.fwd)
        else $error("swap point zero must swap every beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_sc_vld) && $stable(r_vld[MAG_LAT-1])))
        else $error("pipeline moved while held");

endmodule

// ----- tb/testbench.sv -----
// Testbench for the Box-Muller Gaussian pair generator: predictor, scoreboard, stimulus.
module testbench;
    import bmg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // one predicted output beat
    typedef struct {
        logic [31:0] z_first;
        logic [31:0] z_second;
        logic        run_last;
    } t_gauss_beat;

    int unsigned err_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Predictor state: a private copy of the run counter and both registers.
    class gauss_scoreboard;
        logic [31:0] run_len;
        logic [31:0] swap_at;
        logic [31:0] run_pos;
        t_gauss_beat pending[$];
        int unsigned checked;

        function new();
            run_len = 0;
            swap_at = 0;
            run_pos = 0;
            checked = 0;
        endfunction

        function automatic logic [63:0] int_sqrt(input logic [63:0] s);
            logic [63:0] res;
            logic [63:0] bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv >>= 2;
            while (bitv != 0) begin
                if (s >= res + bitv) begin
                    s -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // radius sqrt(-2 ln(x/2^32)) in Q4.28
        function automatic logic [31:0] radius(input logic [31:0] x);
            int p;
            logic [63:0] y;
            logic [63:0] frac;
            logic [63:0] t;
            logic [127:0] prod;
            if (x == 0) return R_SAT;
            p = 31;
            while (x[p] == 1'b0) p--;
            y = 64'(x) << (31 - p);
            frac = 0;
            for (int i = 0; i < LOG_ROUNDS; i++) begin
                y = (y * y) >> 31;
                frac <<= 1;
                if (y >= (64'd1 << 32)) begin
                    y >>= 1;
                    frac |= 1;
                end
            end
            t = (64'(32 - p) << 26) - frac;
            prod = 128'(t) * 128'(LN2_Q32);
            return 32'(int_sqrt(64'(prod >> 1)));
        endfunction

        // Horner series in Q.30; sine or cosine divisors
        function automatic logic [63:0] horner(input logic [63:0] x2, input bit is_sin);
            logic [63:0] v;
            logic [63:0] d;
            v = 64'd1 << 30;
            for (int k = 5; k >= 0; k--) begin
                d = is_sin ? 64'((k + 1) * 2 * ((k + 1) * 2 + 1))
                           : 64'((2 * k + 1) * (2 * k + 2));
                v = (64'd1 << 30) - ((x2 * v) >> 30) / d;
            end
            return v;
        endfunction

        function automatic logic [31:0] apply_scale(input logic [31:0] r,
                                                     input logic [63:0] m, input bit neg);
            logic [63:0] v;
            v = (64'(r) * m + (64'd1 << 29)) >> 30;
            if (neg) v = 64'd0 - v;
            return v[31:0];
        endfunction

        function void note_input(input logic [31:0] u0, input logic [31:0] u1);
            bit fwd;
            bit flip;
            bit cn;
            bit sn;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] r;
            logic [31:0] w;
            logic [31:0] th;
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] sv;
            logic [63:0] cv;
            logic [63:0] s;
            logic [63:0] c;
            logic [63:0] cm;
            logic [63:0] sm;
            logic [31:0] z0;
            logic [31:0] z1;
            t_gauss_beat e;
            fwd = run_pos < swap_at;
            a = fwd ? u0 : u1;
            b = fwd ? u1 : u0;
            r = radius(a);
            w = b & 32'h3FFF_FFFF;
            flip = w >= (32'd1 << 29);
            th = flip ? (32'd1 << 30) - w : w;
            x = (64'(th) * 64'(HALF_PI_Q32) + (64'd1 << 31)) >> 32;
            x2 = (x * x) >> 30;
            sv = (x * horner(x2, 1)) >> 30;
            cv = horner(x2, 0);
            s = flip ? cv : sv;
            c = flip ? sv : cv;
            // quadrant sets which series feeds which output and the signs
            case (b[31:30])
                2'd0: begin cm = c; cn = 0; sm = s; sn = 0; end
                2'd1: begin cm = s; cn = 1; sm = c; sn = 0; end
                2'd2: begin cm = c; cn = 1; sm = s; sn = 1; end
                default: begin cm = s; cn = 0; sm = c; sn = 1; end
            endcase
            z0 = apply_scale(r, cm, cn);
            z1 = apply_scale(r, sm, sn);
            e.run_last = (33'(run_pos) + 33'd1) >= 33'(run_len);
            e.z_first = fwd ? z0 : z1;
            e.z_second = fwd ? z1 : z0;
            run_pos = e.run_last ? 32'd0 : run_pos + 32'd1;
            pending.push_back(e);
        endfunction

        task check_result(input logic [31:0] zf, input logic [31:0] zs,
                          input logic rl);
            t_gauss_beat e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat", zf, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (zf !== e.z_first) report_mismatch("z_first", zf, e.z_first);
            if (zs !== e.z_second) report_mismatch("z_second", zs, e.z_second);
            if (rl !== e.run_last) report_mismatch("run_last", 32'(rl), 32'(e.run_last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_u_first;
    logic [31:0] i_u_second;
    logic        o_out_valid;
    logic        i_out_stall;
    logic signed [31:0] o_z_first;
    logic signed [31:0] o_z_second;
    logic        o_run_last;

    box_muller_gaussian_pair dut (.*);

    gauss_scoreboard sb;

    // idle percentages per side, changed between phases
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned sink_hold = 0;     // long receiver hold-off request, in cycles
    int unsigned idle_cycles = 0;
    int unsigned beats_sent = 0;
    int unsigned runs_closed = 0;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 80;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        i_in_valid = 0;
        i_u_first = 0;
        i_u_second = 0;
        i_out_stall = 0;
    end

    // Receiver: random stall per beat, plus a long counted hold-off when asked.
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            i_out_stall <= 1'b1;
            sink_hold <= sink_hold - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // Output monitor: a beat moves when valid is high and stall low at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_run_last) runs_closed++;
            sb.check_result(o_z_first, o_z_second, o_run_last);
        end
    end

    // Watchdog: cycles with no beat accepted on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_PAIR_COUNT: sb.run_len = val;
            REG_SWAP_POINT: sb.swap_at = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] pcount, input logic [31:0] swp);
        reg_write(REG_PAIR_COUNT, pcount);
        reg_write(REG_SWAP_POINT, swp);
    endtask

    // Send one beat; valid stays high between back-to-back beats.
    task automatic send_pair(input logic [31:0] u0, input logic [31:0] u1);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_u_first <= u0;
        i_u_second <= u1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(u0, u1);
        beats_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random word biased toward small, large and edge values of the log input.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'($urandom_range(3));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(3));
            2: return 32'd1 << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(input int unsigned n, input int unsigned src_pct,
                                input int unsigned sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (n) send_pair(rand_word(), rand_word());
        wait_drained();
    endtask

    initial begin
        logic [31:0] edge_words[8];
        edge_words = '{32'h0, 32'h1, 32'h8000_0000, 32'hFFFF_FFFF,
                       32'h4000_0000, 32'h2000_0000, 32'hC000_0000, 32'h3FFF_FFFF};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset registers (run length zero, swapped order everywhere),
        // zero a saturates, quadrant and octant boundaries of b.
        for (int i = 0; i < 8; i++) send_pair(edge_words[i], edge_words[7 - i]);
        send_pair(32'h0, 32'h0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();

        // Forward order for the first half of a run of four.
        configure(32'd4, 32'd2);
        for (int i = 0; i < 8; i++) send_pair(edge_words[i], edge_words[(i + 3) % 8]);
        wait_drained();

        // Shorten the run below the current index: next pair closes the run.
        configure(32'd10, 32'hFFFF_FFFF);
        repeat (5) send_pair($urandom(), $urandom());
        wait_drained();
        configure(32'd2, 32'hFFFF_FFFF);
        repeat (3) send_pair($urandom(), $urandom());
        wait_drained();

        // Random phases across the idling schedule and register extremes.
        configure(32'd7, 32'd3);
        random_phase(480, 25, 53);
        configure(32'hFFFF_FFFF, 32'd0);
        random_phase(480, 53, 25);
        configure(32'd1, 32'd1);
        random_phase(200, 0, 0);
        configure(32'd13, 32'd6);

        // Long receiver hold-off while the sender keeps offering: the queue fills.
        src_idle_pct = 0;
        sink_idle_pct = 0;
        sink_hold = 200;
        repeat (150) send_pair(rand_word(), rand_word());
        wait_drained();
        configure(32'd0, 32'hFFFF_FFFF);
        random_phase(100, 10, 10);

        $display("Covered %0d pairs, %0d run ends, with both operand orders and stalls.",
                 beats_sent, runs_closed);
        if (err_count == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/bmg_pkg.sv
rtl/core/bmg_magnitude.sv
rtl/core/bmg_trig.sv
rtl/core/box_muller_gaussian_pair.sv
tb/testbench.sv
